FILE: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the max-heap priority queue
// Status codes, controller states, datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;
  localparam int CNT_W_DEF    = $clog2(CAPACITY_DEF + 1);

  // operation codes carried on the input word
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } mhpq_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_SCAN,
    S_DEL_LOAD,
    S_DEL_PAR,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } mhpq_state_t;

  // memory read address source
  typedef enum logic [2:0] {
    RD_SCAN,
    RD_PARENT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } mhpq_rd_sel_t;

  // memory write data source (address is always the hole index)
  typedef enum logic [1:0] {
    WR_CUR,
    WR_RDATA,
    WR_BEST
  } mhpq_wr_sel_t;

  // hole index update
  typedef enum logic [2:0] {
    K_HOLD,
    K_COUNT,
    K_MATCH,
    K_PARENT,
    K_BEST
  } mhpq_k_sel_t;

  typedef struct packed {
    logic         load;
    logic         rd_en;
    mhpq_rd_sel_t rd_sel;
    logic         wr_en;
    mhpq_wr_sel_t wr_sel;
    mhpq_k_sel_t  k_sel;
    logic         scan_step;
    logic         cur_from_rdata;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         dn_right;
    logic         big_cap;
    logic         set_status;
    mhpq_status_t status;
    logic         out_load;
  } mhpq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic k_zero;
    logic cur_gt;
    logic match;
    logic match_last;
    logic scan_last;
    logic scan_more;
    logic l_ok;
    logic r_ok;
    logic best_child;
  } mhpq_sts_t;

  // signed greater-than on raw words
  function automatic logic sgt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mhpq_if.sv
// ----------------------------------------------------------------------------
// mhpq_if: channel interfaces of the max-heap priority queue
// Request channel (op, value) and result channel (status, count, top, empty).
// ----------------------------------------------------------------------------
`default_nettype none

interface mhpq_in_if import mhpq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface mhpq_out_if import mhpq_pkg::*; #(
  parameter int CNT_W = CNT_W_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] top_value;
  logic                     empty_res;

  modport source (output valid, output status, output count, output top_value,
                  output empty_res, input ready);
  modport sink   (input valid, input status, input count, input top_value,
                  input empty_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/mhpq_dp.sv
// ----------------------------------------------------------------------------
// mhpq_dp: heap datapath
// Heap memory with one read and one write port, hole index, scan counters,
// child selection and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_dp import mhpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [DATA_W-1:0] in_value,
  input  wire mhpq_cmd_t         cmd,
  output mhpq_sts_t              sts,
  output logic [1:0]             res_status,
  output logic [CNT_W-1:0]       res_count,
  output logic [DATA_W-1:0]      res_top_value,
  output logic                   res_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int IW = AW + 2;

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              dv_r, dv_nxt;
  logic [AW-1:0]     cmp_r, cmp_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic [DATA_W-1:0] rdata_r;
  logic [DATA_W-1:0] big_val_r, big_val_nxt;
  logic [AW-1:0]     big_idx_r, big_idx_nxt;
  logic              big_child_r, big_child_nxt;
  mhpq_status_t      status_r, status_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [1:0]        res_status_r;
  logic [CNT_W-1:0]  res_count_r;
  logic [DATA_W-1:0] res_top_r;
  logic              res_empty_r;

  logic [AW-1:0]     parent_a;
  logic [AW-1:0]     last_a;
  logic [IW-1:0]     left_i;
  logic [IW-1:0]     right_i;
  logic [IW-1:0]     cnt_ext;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] base_val;
  logic              base_child;
  logic              wins;
  logic [DATA_W-1:0] best_val;
  logic [AW-1:0]     best_idx;
  logic              best_child;

  // index arithmetic around the hole
  assign parent_a = AW'(k_r - AW'(1)) >> 1;
  assign last_a   = AW'(count_r - CNT_W'(1));
  assign left_i   = {1'b0, k_r, 1'b1};
  assign right_i  = left_i + IW'(1);
  assign cnt_ext  = IW'(count_r);

  // pick the larger of the hole value and the children seen so far
  always_comb begin
    base_val   = cmd.dn_right ? big_val_r : cur_r;
    base_child = cmd.dn_right & big_child_r;
    wins       = sgt(rdata_r, base_val);
    best_val   = wins ? rdata_r : base_val;
    best_child = wins | base_child;
    if (wins) begin
      best_idx = cmd.dn_right ? right_i[AW-1:0] : left_i[AW-1:0];
    end else begin
      best_idx = big_idx_r;
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN:   rd_addr = idx_r[AW-1:0];
      RD_PARENT: rd_addr = parent_a;
      RD_LAST:   rd_addr = last_a;
      RD_LEFT:   rd_addr = left_i[AW-1:0];
      RD_RIGHT:  rd_addr = right_i[AW-1:0];
      default:   rd_addr = idx_r[AW-1:0];
    endcase
  end

  // write data select
  always_comb begin
    case (cmd.wr_sel)
      WR_CUR:   wdata = cur_r;
      WR_RDATA: wdata = rdata_r;
      WR_BEST:  wdata = best_val;
      default:  wdata = cur_r;
    endcase
  end

  // heap memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[k_r] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // next values of the datapath registers
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    dv_nxt        = 1'b0;
    cmp_nxt       = cmp_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    big_val_nxt   = big_val_r;
    big_idx_nxt   = big_idx_r;
    big_child_nxt = big_child_r;
    status_nxt    = status_r;
    top_nxt       = top_r;

    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end

    if (cmd.load) begin
      idx_nxt = '0;
      cur_nxt = in_value;
    end else if (cmd.scan_step) begin
      idx_nxt = idx_r + CNT_W'(1);
      cmp_nxt = idx_r[AW-1:0];
      dv_nxt  = 1'b1;
    end

    if (cmd.cur_from_rdata) begin
      cur_nxt = rdata_r;
    end

    case (cmd.k_sel)
      K_HOLD:   k_nxt = k_r;
      K_COUNT:  k_nxt = count_r[AW-1:0];
      K_MATCH:  k_nxt = cmp_r;
      K_PARENT: k_nxt = parent_a;
      K_BEST:   k_nxt = best_idx;
      default:  k_nxt = k_r;
    endcase

    if (cmd.big_cap) begin
      big_val_nxt   = best_val;
      big_idx_nxt   = best_idx;
      big_child_nxt = best_child;
    end

    if (cmd.set_status) begin
      status_nxt = cmd.status;
    end

    // shadow of slot zero for the result word
    if (cmd.wr_en && k_r == '0) begin
      top_nxt = wdata;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dv_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      dv_r    <= dv_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cmp_r       <= cmp_nxt;
    k_r         <= k_nxt;
    cur_r       <= cur_nxt;
    big_val_r   <= big_val_nxt;
    big_idx_r   <= big_idx_nxt;
    big_child_r <= big_child_nxt;
    status_r    <= status_nxt;
    top_r       <= top_nxt;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_status_r <= status_r;
      res_count_r  <= count_r;
      res_top_r    <= (count_r == '0) ? '0 : top_r;
      res_empty_r  <= (count_r == '0);
    end
  end

  assign res_status    = res_status_r;
  assign res_count     = res_count_r;
  assign res_top_value = res_top_r;
  assign res_empty     = res_empty_r;

  // status toward the controller
  always_comb begin
    sts.full       = (count_r == CNT_W'(CAPACITY));
    sts.empty      = (count_r == '0);
    sts.k_zero     = (k_r == '0);
    sts.cur_gt     = sgt(cur_r, rdata_r);
    sts.match      = dv_r && (rdata_r == cur_r);
    sts.match_last = (cmp_r == last_a);
    sts.scan_last  = dv_r && (cmp_r == last_a);
    sts.scan_more  = (idx_r < count_r);
    sts.l_ok       = (left_i < cnt_ext);
    sts.r_ok       = (right_i < cnt_ext);
    sts.best_child = best_child;
  end

endmodule

`default_nettype wire

FILE: rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl: heap controller
// Sequences insert, linear search, sift up and sift down over the datapath,
// and holds the valid of the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl import mhpq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_op,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire mhpq_sts_t sts,
  output mhpq_cmd_t      cmd
);

  mhpq_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.rd_sel = RD_SCAN;
    cmd.wr_sel = WR_CUR;
    cmd.k_sel  = K_HOLD;
    cmd.status = ST_OK;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.set_status = 1'b1;
          if (in_op == OP_INSERT) begin
            if (sts.full) begin
              cmd.status = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              cmd.k_sel   = K_COUNT;
              cmd.cnt_inc = 1'b1;
              state_nxt   = S_UP_CHK;
            end
          end else if (sts.empty) begin
            cmd.status = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // sift up: fetch parent of the hole, or settle at the root
      S_UP_CHK: begin
        if (sts.k_zero) begin
          cmd.wr_en = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.cur_gt) begin
          cmd.wr_sel = WR_RDATA;
          cmd.k_sel  = K_PARENT;
          state_nxt  = S_UP_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // linear search, one read issued per cycle
      S_SCAN: begin
        if (sts.match) begin
          cmd.k_sel   = K_MATCH;
          cmd.cnt_dec = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_LAST;
          state_nxt   = sts.match_last ? S_DONE : S_DEL_LOAD;
        end else if (sts.scan_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else if (sts.scan_more) begin
          cmd.rd_en     = 1'b1;
          cmd.scan_step = 1'b1;
        end
      end

      // last entry arrives; it fills the hole
      S_DEL_LOAD: begin
        cmd.cur_from_rdata = 1'b1;
        if (sts.k_zero) begin
          state_nxt = S_DN_RDL;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_nxt  = S_DEL_PAR;
        end
      end

      S_DEL_PAR: begin
        if (sts.cur_gt) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_RDATA;
          cmd.k_sel  = K_PARENT;
          state_nxt  = S_UP_CHK;
        end else begin
          state_nxt = S_DN_RDL;
        end
      end

      // sift down: fetch left child, or settle at a leaf
      S_DN_RDL: begin
        if (sts.l_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_nxt  = S_DN_RDR;
        end else begin
          cmd.wr_en = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DN_RDR: begin
        cmd.big_cap = 1'b1;
        if (sts.r_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_RIGHT;
          state_nxt  = S_DN_CMP;
        end else if (sts.best_child) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_BEST;
          cmd.k_sel  = K_BEST;
          state_nxt  = S_DN_RDL;
        end else begin
          cmd.wr_en = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DN_CMP: begin
        cmd.dn_right = 1'b1;
        cmd.wr_en    = 1'b1;
        if (sts.best_child) begin
          cmd.wr_sel = WR_BEST;
          cmd.k_sel  = K_BEST;
          state_nxt  = S_DN_RDL;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // hand the word to the result register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/max_heap_priority_queue.sv
// From accepting a word to result valid: an insert into a full heap goes straight
//   to the result, else it sifts up level by level; a delete on an empty heap does
//   too, with no match it scans every entry, else it scans to the match and sifts.
// Throughput: one word at a time, next word taken the cycle after the result loads;
//   the single read port of the heap memory sets the pace.
// Reset: synchronous, clears entry count, controller and result valid; no heap clear.
// ----------------------------------------------------------------------------
// max_heap_priority_queue: binary max-heap of signed 32-bit values
// Insert with sift up, delete of first equal entry with sift up or down.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mhpq_in_if.sink    in_ch,
  mhpq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  mhpq_cmd_t         cmd;
  mhpq_sts_t         sts;
  logic [1:0]        res_status;
  logic [CNT_W-1:0]  res_count;
  logic [DATA_W-1:0] res_top_value;
  logic              res_empty;
  logic              in_ready;
  logic              out_valid;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mhpq_dp #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_ch.value),
    .cmd           (cmd),
    .sts           (sts),
    .res_status    (res_status),
    .res_count     (res_count),
    .res_top_value (res_top_value),
    .res_empty     (res_empty)
  );

  // drive channel ports
  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.status    = res_status;
  assign out_ch.count     = res_count;
  assign out_ch.top_value = res_top_value;
  assign out_ch.empty_res = res_empty;

endmodule

`default_nettype wire

FILE: rtl/mhpq_checker.sv
// ----------------------------------------------------------------------------
// mhpq_checker: port-level checks of the max-heap priority queue
// Result word consistency and hold under backpressure, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker import mhpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        out_status,
  input wire logic [CNT_W-1:0]  out_count,
  input wire logic [DATA_W-1:0] out_top_value,
  input wire logic              out_empty_res
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_count) && $stable(out_top_value) && $stable(out_empty_res))
    else $error("result word changed while stalled");

  // empty flag agrees with count
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("empty flag disagrees with count");

  // empty heap reports zero top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_top_value == '0)
    else $error("top value nonzero on empty heap");

  // count stays within capacity
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // status is a known code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL ||
      out_status == ST_NOT_FOUND))
    else $error("unknown status code");

endmodule

bind max_heap_priority_queue mhpq_checker #(
  .CAPACITY (CAPACITY)
) u_mhpq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_count     (out_ch.count),
  .out_top_value (out_ch.top_value),
  .out_empty_res (out_ch.empty_res)
);

`default_nettype wire
